// File: hdl/gcd_pkg.sv
// shared command and status types for the gcd/lcm unit
package gcd_pkg;

  // width of the operand and result fields on the ports
  localparam int FIELD_W = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture a new request word
    logic halve_both;  // strip a common factor of two
    logic reduce;      // one binary reduction step
    logic latch_gcd;   // store divisor, set up the divide
    logic div_step;    // one restoring divide step
    logic div_last;    // last divide step, clears the accumulator
    logic mul_step;    // one shift-add multiply step
    logic load_out;    // write the result register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic zero;    // an operand is zero
    logic x_odd;
    logic y_odd;
    logic equal;   // x equals y
    logic op_lcm;  // request asks for the multiple
  } sts_t;

endpackage

// File: hdl/gcd_req_if.sv
// request channel: operation selector and two operands
interface gcd_req_if;
  import gcd_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [FIELD_W-1:0] operand_a;
  logic [FIELD_W-1:0] operand_b;

  modport source (output valid, output req_type, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input req_type, input operand_a, input operand_b,
                output ready);
endinterface

// File: hdl/gcd_rsp_if.sv
// response channel: result value and overflow flag
interface gcd_rsp_if;
  import gcd_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] result_value;
  logic               overflow;

  modport source (output valid, output result_value, output overflow, input ready);
  modport sink (input valid, input result_value, input overflow, output ready);
endinterface

// File: hdl/gcd_lcm_unit.sv
// top level of the greatest common divisor / lowest common multiple unit
// sequence: a zero operand goes straight to the result; the divisor takes the common-twos
// strip plus the binary reduction loop; the multiple adds the bit-serial divide and the
// bit-serial multiply
// one request at a time; the next word is taken the cycle after the result is loaded
// reset clears the state machine and the response valid flag; no memory to clear
module gcd_lcm_unit
  import gcd_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  gcd_req_if.sink  req,
  gcd_rsp_if.source rsp
);

  cmd_t             cmd;
  sts_t             sts;
  logic [WIDTH-1:0] in_a, in_b, out_value;
  logic             out_ovf;

  // operands taken modulo 2^WIDTH
  assign in_a = WIDTH'(req.operand_a);
  assign in_b = WIDTH'(req.operand_b);

  assign rsp.result_value = FIELD_W'(out_value);
  assign rsp.overflow     = out_ovf;

  // sequencer
  gcd_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic
  gcd_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .sts       (sts),
    .in_type   (req.req_type),
    .in_a      (in_a),
    .in_b      (in_b),
    .out_value (out_value),
    .out_ovf   (out_ovf)
  );

endmodule

// File: hdl/gcd_ctrl.sv
// controller state machine for the gcd/lcm unit
module gcd_ctrl
  import gcd_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int CW = $clog2(WIDTH);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_TWOS   = 6'b000010,
    S_REDUCE = 6'b000100,
    S_DIV    = 6'b001000,
    S_MUL    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          rsp_valid_next;
  logic          cnt_last;

  assign cnt_last  = (cnt == CW'(WIDTH - 1));
  assign req_ready = (state == S_IDLE);

  // next state, step counter and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_TWOS;
        end
      end
      S_TWOS: begin
        if (sts.zero) begin
          state_next = S_DONE;
        end else if (sts.x_odd || sts.y_odd) begin
          state_next = S_REDUCE;
        end else begin
          cmd.halve_both = 1'b1;
        end
      end
      S_REDUCE: begin
        if (sts.x_odd && sts.y_odd && sts.equal) begin
          cmd.latch_gcd = 1'b1;
          cnt_next      = '0;
          state_next    = sts.op_lcm ? S_DIV : S_DONE;
        end else begin
          cmd.reduce = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt_last) begin
          cmd.div_last = 1'b1;
          cnt_next     = '0;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt_last) begin
          cnt_next   = '0;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // response valid flag
  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.load_out) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// File: hdl/gcd_dp.sv
// datapath: binary gcd reduction, serial divide and serial multiply
module gcd_dp
  import gcd_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic             in_type,
  input  logic [WIDTH-1:0] in_a,
  input  logic [WIDTH-1:0] in_b,
  output logic [WIDTH-1:0] out_value,
  output logic             out_ovf
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] x, y, g, acc, quo, a_keep, b_keep;
  logic [CW-1:0]    k;
  logic             op;

  logic [WIDTH:0]   dxy, dyx, trial, sum;
  logic [WIDTH-1:0] res_value;
  logic             res_ovf;

  // differences for the reduction step
  assign dxy = {1'b0, x} - {1'b0, y};
  assign dyx = {1'b0, y} - {1'b0, x};

  // restoring divide trial and shift-add sum
  assign trial = {acc, quo[WIDTH-1]} - {1'b0, g};
  assign sum   = {1'b0, acc} + (quo[0] ? {1'b0, b_keep} : '0);

  // status to the controller
  assign sts.zero   = (a_keep == '0) || (b_keep == '0);
  assign sts.x_odd  = x[0];
  assign sts.y_odd  = y[0];
  assign sts.equal  = (x == y);
  assign sts.op_lcm = op;

  // result selection
  always_comb begin
    res_value = g;
    res_ovf   = 1'b0;
    if (sts.zero) begin
      res_value = op ? '0 : (a_keep | b_keep);
    end else if (op) begin
      res_value = quo;
      res_ovf   = |acc;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x      <= in_a;
      y      <= in_b;
      a_keep <= in_a;
      b_keep <= in_b;
      op     <= in_type;
      k      <= '0;
    end else if (cmd.halve_both) begin
      x <= x >> 1;
      y <= y >> 1;
      k <= k + 1'b1;
    end else if (cmd.reduce) begin
      if (x[0] && y[0]) begin
        // both odd: halve the difference into the larger one
        if (dxy[WIDTH]) begin
          y <= dyx[WIDTH:1];
        end else begin
          x <= dxy[WIDTH:1];
        end
      end else begin
        if (!x[0]) begin
          x <= x >> 1;
        end
        if (!y[0]) begin
          y <= y >> 1;
        end
      end
    end else if (cmd.latch_gcd) begin
      g   <= x << k;
      acc <= '0;
      quo <= a_keep;
    end else if (cmd.div_step) begin
      quo <= {quo[WIDTH-2:0], ~trial[WIDTH]};
      if (cmd.div_last) begin
        acc <= '0;
      end else if (!trial[WIDTH]) begin
        acc <= trial[WIDTH-1:0];
      end else begin
        acc <= {acc[WIDTH-2:0], quo[WIDTH-1]};
      end
    end else if (cmd.mul_step) begin
      acc <= sum[WIDTH:1];
      quo <= {sum[0], quo[WIDTH-1:1]};
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value <= res_value;
      out_ovf   <= res_ovf;
    end
  end

endmodule

// File: sim/tb.sv
// self-checking testbench for the gcd/lcm unit: random and directed words, scoreboard compare
module tb
  import gcd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // operation selector on the request word
  typedef enum bit {
    OP_GCD = 1'b0,
    OP_LCM = 1'b1
  } gcd_op_e;

  typedef struct {
    gcd_op_e            op;
    bit [FIELD_W-1:0]   a;
    bit [FIELD_W-1:0]   b;
    bit                 hold_for_drain;  // sender waits for all results before offering
  } req_word_t;

  typedef struct {
    bit [FIELD_W-1:0] value;
    bit               ovf;
  } gcd_result_t;

  localparam int IDLE_PCT     = 38;
  localparam int RAND_WORDS   = 1200;
  localparam int HOLDOFF_AT   = 300;   // results seen before the long receiver stall
  localparam int HOLDOFF_LEN  = 600;
  localparam int CALM_LO      = 600;   // no-idle window, in words
  localparam int CALM_HI      = 800;
  localparam int TAIL_CYCLES  = 250;
  localparam int STALL_LIMIT  = 5000;
  localparam int MAX_REPORTS  = 10;

  logic clk;
  logic rst;

  gcd_req_if req_ch ();
  gcd_rsp_if rsp_ch ();

  gcd_lcm_unit #(.WIDTH(32)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  req_word_t   word_q[$];
  gcd_result_t result_q[$];
  req_word_t   offered_word;

  int words_total;
  int words_sent;
  int results_seen;
  int mismatches;
  int n_gcd;
  int n_lcm;
  int n_zero_op;
  int n_overflow;
  int stall_left;
  bit stall_done;
  int quiet_cycles;

  // binary gcd, zero operand gives the OR of both
  function automatic bit [FIELD_W-1:0] binary_gcd(bit [FIELD_W-1:0] x, bit [FIELD_W-1:0] y);
    int               twos;
    bit [FIELD_W-1:0] t;
    if (x == '0 || y == '0) return x | y;
    twos = 0;
    while (!x[0] && !y[0]) begin
      x = x >> 1;
      y = y >> 1;
      twos++;
    end
    while (!x[0]) x = x >> 1;
    while (y != '0) begin
      while (!y[0]) y = y >> 1;
      if (x > y) begin
        t = x;
        x = y;
        y = t;
      end
      y = y - x;
    end
    return x << twos;
  endfunction

  // expected response for one request word
  function automatic gcd_result_t predict_result(req_word_t w);
    gcd_result_t      r;
    bit [FIELD_W-1:0] g;
    bit [FIELD_W-1:0] q;
    bit [63:0]        prod;
    r.value = '0;
    r.ovf   = 1'b0;
    if (w.op == OP_GCD) begin
      r.value = binary_gcd(w.a, w.b);
    end else if (w.a != '0 && w.b != '0) begin
      g      = binary_gcd(w.a, w.b);
      q      = w.a / g;
      prod   = {32'b0, q} * {32'b0, w.b};
      r.value = prod[FIELD_W-1:0];
      r.ovf   = (prod[63:FIELD_W] != '0);
    end
    return r;
  endfunction

  task automatic add_word(gcd_op_e op, bit [FIELD_W-1:0] a, bit [FIELD_W-1:0] b,
                          bit hold = 1'b0);
    req_word_t w;
    w.op             = op;
    w.a              = a;
    w.b              = b;
    w.hold_for_drain = hold;
    word_q.push_back(w);
    words_total++;
  endtask

  // clock and reset
  always #2 clk = ~clk;

  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = 1'b0;
    req_ch.operand_a   = '0;
    req_ch.operand_b   = '0;
    rsp_ch.ready       = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // request driver
  always @(posedge clk) begin : drive_req
    req_word_t nxt;
    bit        offer;
    bit        calm;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        result_q.push_back(predict_result(offered_word));
        words_sent++;
        if (offered_word.op == OP_GCD) n_gcd++;
        else n_lcm++;
        if (offered_word.a == '0 || offered_word.b == '0) n_zero_op++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        offer = 1'b0;
        calm  = (words_sent >= CALM_LO && words_sent < CALM_HI);
        if (word_q.size() != 0 && !(word_q[0].hold_for_drain && result_q.size() != 0)) begin
          if (calm || $urandom_range(0, 99) >= IDLE_PCT) begin
            nxt          = word_q.pop_front();
            offered_word = nxt;
            offer        = 1'b1;
          end
        end
        req_ch.valid <= offer;
        if (offer) begin
          req_ch.req_type  <= nxt.op;
          req_ch.operand_a <= nxt.a;
          req_ch.operand_b <= nxt.b;
        end
      end
    end
  end

  // response checker and ready pattern
  always @(posedge clk) begin : collect_rsp
    gcd_result_t want;
    bit          take;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected result word value=%h ovf=%b", $realtime,
                     rsp_ch.result_value, rsp_ch.overflow);
        end else begin
          want = result_q.pop_front();
          if (want.ovf) n_overflow++;
          if (rsp_ch.result_value !== want.value || rsp_ch.overflow !== want.ovf) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("[%0t] result %0d mismatch: value exp %h got %h, ovf exp %b got %b",
                       $realtime, results_seen, want.value, rsp_ch.result_value,
                       want.ovf, rsp_ch.overflow);
          end
        end
      end
      // one long hold-off so the unit backs up into the request side
      if (stall_left != 0) begin
        stall_left--;
        take = 1'b0;
      end else if (results_seen == HOLDOFF_AT && !stall_done) begin
        stall_done = 1'b1;
        stall_left = HOLDOFF_LEN;
        take       = 1'b0;
      end else begin
        take = (results_seen >= CALM_LO && results_seen < CALM_HI) ||
               ($urandom_range(0, 99) >= IDLE_PCT);
      end
      rsp_ch.ready <= take;
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    bit [FIELD_W-1:0] a;
    bit [FIELD_W-1:0] b;
    bit [FIELD_W-1:0] g;
    gcd_op_e          op;
    int               kind;

    // directed corners
    add_word(OP_GCD, 32'd0, 32'd0);
    add_word(OP_GCD, 32'd0, 32'h8000_0001);
    add_word(OP_GCD, 32'hFFFF_FFFF, 32'd0);
    add_word(OP_LCM, 32'd0, 32'd0);
    add_word(OP_LCM, 32'd0, 32'h1234_5678);
    add_word(OP_LCM, 32'hFFFF_FFFF, 32'd0);
    add_word(OP_GCD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(OP_GCD, 32'd1, 32'hFFFF_FFFF);
    add_word(OP_GCD, 32'h8000_0000, 32'h4000_0000);
    add_word(OP_GCD, 32'h8000_0000, 32'h8000_0000);
    add_word(OP_GCD, 32'd48, 32'd180);
    add_word(OP_GCD, 32'hFFFF_FFFB, 32'hFFFF_FFF1);
    add_word(OP_GCD, 32'h0001_0000, 32'h0000_0003);
    add_word(OP_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(OP_LCM, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    add_word(OP_LCM, 32'd1, 32'd1);
    add_word(OP_LCM, 32'd6, 32'd4);
    add_word(OP_LCM, 32'h0001_0000, 32'h0001_0000);
    add_word(OP_LCM, 32'h0001_0000, 32'h0001_0001);
    add_word(OP_LCM, 32'h0000_FFFF, 32'h0001_0001);
    add_word(OP_LCM, 32'h8000_0000, 32'd3);
    add_word(OP_LCM, 32'h8000_0000, 32'd2);

    // random words, shaped toward shared factors and small products
    for (int i = 0; i < RAND_WORDS; i++) begin
      op   = gcd_op_e'($urandom_range(0, 1));
      kind = $urandom_range(0, 9);
      a    = $urandom();
      b    = $urandom();
      case (kind)
        0: begin
          if ($urandom_range(0, 1)) a = '0;
          else b = '0;
        end
        3, 4: begin
          g = $urandom_range(1, 65535) << $urandom_range(0, 8);
          a = g * $urandom_range(1, 32767);
          b = g * $urandom_range(1, 32767);
        end
        5, 6: begin
          a = $urandom_range(1, 65535);
          b = $urandom_range(1, 65535);
        end
        7: b = a;
        8: begin
          a = $urandom_range(1, 255) << $urandom_range(0, 24);
          b = $urandom_range(1, 255) << $urandom_range(0, 24);
        end
        9: begin
          a = a >> $urandom_range(0, 31);
          b = b >> $urandom_range(0, 31);
        end
        default: ;
      endcase
      add_word(op, a, b, (i == 400 || i == 900));
    end

    while (words_sent != words_total) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d divisor and %0d multiple requests, %0d with a zero operand",
             n_gcd, n_lcm, n_zero_op);
    $display("%0d multiples overflowed, %0d mismatches", n_overflow, mismatches);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
